@@ design/bfa_pkg.sv @@
// Package for the bitmap first-fit block allocator: request/result types,
// opcodes, sizing constants. No dependencies.
`default_nettype none
package bfa_pkg;

  localparam int unsigned BitmapWordsDef = 16;
  localparam int unsigned WordBits       = 64;
  localparam int unsigned BlockIdxW      = 10;
  localparam int unsigned CountW         = 11;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [CountW-1:0]    block_count;
    logic [BlockIdxW-1:0] start_block;
  } req_t;

  typedef struct packed {
    logic                 status;
    logic [BlockIdxW-1:0] first_block;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture request, reset scan
    logic scan_rd;    // issue bitmap read of scan word
    logic scan_step;  // examine one block of the scan
    logic mark_step;  // set/clear one block
    logic len_rd;     // read recorded length
    logic len_ld;     // latch length for free
    logic len_wr;     // record length at start block
    logic flush;      // write back dirty word
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_free;
    logic bad_req;    // zero size / too large / free out of range
    logic word_full;  // current word fully used (at word start)
    logic found;
    logic scan_end;   // scan past last block
    logic word_end;   // current block is last of its word
    logic mark_done;
  } sts_t;

endpackage
`default_nettype wire

@@ design/bfa_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

@@ design/bfa_ctrl.sv @@
// Controller FSM of the allocator: sequences scan, length lookup and marking.
// Uses bfa_pkg command/status types.
`default_nettype none
module bfa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          clr_done_i,
  input  wire bfa_pkg::sts_t sts_i,
  output bfa_pkg::cmd_t      cmd_o,
  output logic               busy_o,
  output logic               done_o,
  output logic               fail_o
);
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_WAIT  = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_LEN   = 8'b0010_0000,
    S_MARK  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   fail_q, fail_d;
  logic   mark_q, mark_d;   // run set/clear under way

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      fail_q  <= 1'b0;
      mark_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fail_q  <= fail_d;
      mark_q  <= mark_d;
    end
  end

  always_comb begin
    state_d = state_q;
    fail_d  = fail_q;
    mark_d  = mark_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        if (clr_done_i) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          mark_d     = 1'b0;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        if (mark_q) begin
          // run continues into the next word
          cmd_o.scan_rd = 1'b1;
          state_d       = S_WAIT;
        end else if (sts_i.bad_req) begin
          fail_d  = !sts_i.is_free;
          state_d = S_DONE;
        end else if (sts_i.is_free) begin
          cmd_o.len_rd = 1'b1;
          state_d      = S_LEN;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_WAIT;
        end
      end
      S_WAIT: state_d = mark_q ? S_MARK : S_SCAN;
      S_LEN: begin
        cmd_o.len_ld = 1'b1;
        state_d      = S_WAIT;
      end
      S_SCAN: begin
        if (sts_i.is_free) begin
          mark_d  = 1'b1;
          state_d = S_MARK;
        end else if (sts_i.scan_end) begin
          fail_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.found) begin
            cmd_o.len_wr = 1'b1;
            mark_d       = 1'b1;
            state_d      = S_MARK;
          end else if (sts_i.word_full || sts_i.word_end) begin
            state_d = S_RD;
          end
        end
      end
      S_MARK: begin
        if (sts_i.mark_done) begin
          cmd_o.flush = 1'b1;
          fail_d      = 1'b0;
          state_d     = S_DONE;
        end else begin
          cmd_o.mark_step = 1'b1;
          if (sts_i.word_end) state_d = S_RD;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign fail_o = fail_q;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_IDLE) else $error("load outside idle");
  a_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.scan_step && cmd_o.mark_step)) else $error("scan and mark together");
`endif
endmodule
`default_nettype wire

@@ design/bfa_dp.sv @@
// Datapath: bitmap and run-length RAMs, block pointer, run counter.
// Uses bfa_pkg, bfa_ram.
`default_nettype none
module bfa_dp #(
  parameter int unsigned BitmapWords = bfa_pkg::BitmapWordsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bfa_pkg::req_t req_i,
  input  wire bfa_pkg::cmd_t cmd_i,
  input  wire logic          done_i,
  output bfa_pkg::sts_t      sts_o,
  output logic               clr_done_o,
  output logic [bfa_pkg::BlockIdxW-1:0] first_o
);
  localparam int unsigned NumBlocks = BitmapWords * bfa_pkg::WordBits;
  localparam int unsigned BW = $clog2(NumBlocks) + 1;   // holds NumBlocks
  localparam int unsigned AW = $clog2(NumBlocks);
  localparam int unsigned WA = (BitmapWords > 1) ? $clog2(BitmapWords) : 1;
  localparam int unsigned CW = bfa_pkg::CountW;

  // scan / mark pointer and registers
  logic [BW-1:0] blk_q, blk_d;       // current block
  logic [BW-1:0] end_q, end_d;       // mark end (exclusive)
  logic [BW-1:0] first_q, first_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [BW-1:0] run_q, run_d;
  logic          op_q, op_d;
  logic [BW-1:0] clr_q, clr_d;       // clearing sweep counter
  logic          clr_busy;
  logic [BW-1:0] sblk;
  logic [63:0]   word_q, word_d;     // working copy of current word
  logic [WA-1:0] wadr_q, wadr_d;     // word held in word_q
  logic          first_rd_q, first_rd_d; // word_q awaits ram data

  logic [63:0]   bm_rdata;
  logic          bm_we;
  logic [WA-1:0] bm_addr;
  logic [63:0]   bm_wdata;
  logic [CW-1:0] len_rdata;
  logic          len_we;
  logic [AW-1:0] len_addr;
  logic [CW-1:0] len_wdata;

  logic [5:0]    bit_idx;
  logic [63:0]   cur_word;
  logic          cur_used;
  logic [WA-1:0] blk_word;

  assign clr_busy = (clr_q != BW'(NumBlocks));
  assign clr_done_o = !clr_busy;
  assign bit_idx  = blk_q[5:0];
  assign blk_word = WA'(blk_q >> 6);
  assign cur_word = first_rd_q ? bm_rdata : word_q;
  assign cur_used = cur_word[6'd63 - bit_idx];
  assign sblk = BW'(req_i.start_block);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      first_rd_q <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      first_rd_q <= first_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q   <= blk_d;
    end_q   <= end_d;
    first_q <= first_d;
    cnt_q   <= cnt_d;
    run_q   <= run_d;
    op_q    <= op_d;
    word_q  <= word_d;
    wadr_q  <= wadr_d;
  end

  always_comb begin
    clr_d      = clr_busy ? clr_q + 1'b1 : clr_q;
    blk_d      = blk_q;
    end_d      = end_q;
    first_d    = first_q;
    cnt_d      = cnt_q;
    run_d      = run_q;
    op_d       = op_q;
    word_d     = cur_word;
    wadr_d     = wadr_q;
    first_rd_d = 1'b0;
    bm_we      = 1'b0;
    bm_addr    = blk_word;
    bm_wdata   = word_q;
    len_we     = 1'b0;
    len_addr   = AW'(blk_q);
    len_wdata  = cnt_q;

    if (clr_busy) begin
      bm_we     = 1'b1;
      bm_addr   = WA'(clr_q);
      bm_wdata  = '0;
      len_we    = 1'b1;
      len_addr  = AW'(clr_q);
      len_wdata = '0;
    end
    if (cmd_i.load) begin
      op_d    = req_i.opcode;
      cnt_d   = req_i.block_count;
      blk_d   = (req_i.opcode == bfa_pkg::OP_FREE) ? sblk : '0;
      run_d   = '0;
      first_d = '0;
    end
    if (cmd_i.scan_rd) begin
      // write back previous dirty word happens in mark; here just read
      bm_addr    = blk_word;
      wadr_d     = blk_word;
      first_rd_d = 1'b1;
    end
    if (cmd_i.len_rd) begin
      len_addr = AW'(blk_q);
      bm_addr  = blk_word;
    end
    if (cmd_i.len_ld) begin
      end_d = ((BW+1)'(blk_q) + (BW+1)'(len_rdata) > (BW+1)'(NumBlocks))
              ? BW'(NumBlocks) : BW'(blk_q + BW'(len_rdata));
      bm_addr    = blk_word;
      wadr_d     = blk_word;
      first_rd_d = 1'b1;
    end
    if (cmd_i.scan_step) begin
      if (bit_idx == 6'd0 && cur_word == 64'hffff_ffff_ffff_ffff) begin
        run_d = '0;
        blk_d = blk_q + BW'(64);
      end else if (cur_used) begin
        run_d = '0;
        blk_d = blk_q + 1'b1;
      end else begin
        run_d = run_q + 1'b1;
        if (run_q == '0) first_d = blk_q;
        blk_d = blk_q + 1'b1;
        if (BW'(run_q + 1'b1) == BW'(cnt_q)) begin
          // start marking at run start
          blk_d      = (run_q == '0) ? blk_q : first_q;
          end_d      = blk_q + 1'b1;
          len_we     = 1'b1;
          len_addr   = AW'((run_q == '0) ? blk_q : first_q);
          len_wdata  = cnt_q;
          wadr_d     = WA'(((run_q == '0) ? blk_q : first_q) >> 6);
          first_rd_d = (WA'(((run_q == '0) ? blk_q : first_q) >> 6) != wadr_q);
          bm_addr    = WA'(((run_q == '0) ? blk_q : first_q) >> 6);
        end
      end
    end
    if (cmd_i.mark_step) begin
      word_d[6'd63 - bit_idx] = !op_q;
      blk_d = blk_q + 1'b1;
      if (bit_idx == 6'd63) begin
        bm_we    = 1'b1;
        bm_addr  = wadr_q;
        bm_wdata = word_d;
      end
    end
    if (cmd_i.flush) begin
      bm_we    = 1'b1;
      bm_addr  = wadr_q;
      bm_wdata = cur_word;
    end
  end

  bfa_ram #(.Width(64), .Depth(BitmapWords)) u_bitmap (
    .clk_i, .we_i(bm_we), .addr_i(bm_addr), .wdata_i(bm_wdata), .rdata_o(bm_rdata)
  );
  bfa_ram #(.Width(CW), .Depth(NumBlocks)) u_len (
    .clk_i, .we_i(len_we), .addr_i(len_addr), .wdata_i(len_wdata), .rdata_o(len_rdata)
  );

  always_comb begin
    sts_o           = '0;
    sts_o.is_free   = op_q;
    sts_o.bad_req   = op_q ? (blk_q >= BW'(NumBlocks))
                           : (cnt_q == '0 || (CW+1)'(cnt_q) > (CW+1)'(NumBlocks));
    sts_o.word_full = (bit_idx == 6'd0) && (cur_word == 64'hffff_ffff_ffff_ffff);
    sts_o.found     = !cur_used && !sts_o.word_full && (BW'(run_q + 1'b1) == BW'(cnt_q));
    sts_o.scan_end  = (blk_q >= BW'(NumBlocks));
    sts_o.word_end  = (bit_idx == 6'd63);
    sts_o.mark_done = (blk_q >= end_q);
  end

  assign first_o = (done_i) ? first_q[bfa_pkg::BlockIdxW-1:0] : '0;

`ifndef SYNTHESIS
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_step |-> blk_q < end_q) else $error("mark past end");
  a_clr_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !cmd_i.load) else $error("request during clear");
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> run_q < BW'(cnt_q)) else $error("run overrun");
`endif
endmodule
`default_nettype wire

@@ design/bitmap_first_fit_block_allocator_core.sv @@
// Top level of the bitmap first-fit block allocator.
// Depends on bfa_pkg, bfa_ctrl, bfa_dp (and bfa_ram through bfa_dp).
`default_nettype none
// Command-style block: a request is taken when start is high and busy is
// low; one result appears on rsp_o for a single cycle with done_o high and
// cannot be held off. After reset the block sweeps both memories clear, one
// entry a cycle, with busy high. An allocate walks the bitmap one block a
// cycle (a fully used word is skipped in one step) and then sets the run one
// block a cycle, both pausing whenever a new word is read from the bitmap
// RAM; a free reads the recorded length and clears that many blocks the same
// way, stopping at the end of the bitmap.
module bitmap_first_fit_block_allocator_core #(
  parameter int unsigned BITMAP_WORDS = bfa_pkg::BitmapWordsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire bfa_pkg::req_t req_i,
  output logic               busy,
  output logic               done_o,
  output bfa_pkg::rsp_t      rsp_o
);
  bfa_pkg::cmd_t cmd;
  bfa_pkg::sts_t sts;
  logic          clr_done;
  logic          fail;
  logic [bfa_pkg::BlockIdxW-1:0] first;

  bfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .clr_done_i(clr_done), .sts_i(sts),
    .cmd_o(cmd), .busy_o(busy), .done_o, .fail_o(fail)
  );

  bfa_dp #(.BitmapWords(BITMAP_WORDS)) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .done_i(done_o && !fail && !sts.is_free),
    .sts_o(sts), .clr_done_o(clr_done), .first_o(first)
  );

  assign rsp_o.status      = fail ? bfa_pkg::STATUS_FAIL : bfa_pkg::STATUS_OK;
  assign rsp_o.first_block = first;
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for bitmap_first_fit_block_allocator_core: directed and random
// allocate/free requests checked against an in-bench first-fit bitmap model.
// Depends on bfa_pkg and the allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int unsigned NumBlocks   = bfa_pkg::BitmapWordsDef * bfa_pkg::WordBits;
  localparam int unsigned CycleLimit  = 15_000_000;
  localparam int unsigned RandomReqs  = 1330;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  bfa_pkg::req_t req_i;
  logic          busy;
  logic          done_o;
  bfa_pkg::rsp_t rsp_o;

  bitmap_first_fit_block_allocator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // Mirror of the allocator state: one used flag per block, plus the length
  // recorded at the first block of each allocated run.
  bit          blk_used [NumBlocks];
  logic [10:0] run_len  [NumBlocks];

  bfa_pkg::rsp_t rsp_due_q[$];
  int   live_runs_q[$];
  int   cycles, mismatches, rsp_checked;
  int   alloc_ok, alloc_failed, frees;
  int   burst_left;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, rsp_due_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // First-fit over blocks in index order. Skipping full words in the RTL
  // gives the same answer: a full word breaks any run anyway.
  function automatic bfa_pkg::rsp_t alloc_free_step(bfa_pkg::req_t r);
    bfa_pkg::rsp_t res;
    int   run, first, stop;
    bit   found;
    res = '0;
    run = 0;
    first = 0;
    found = 1'b0;
    if (r.opcode == bfa_pkg::OP_ALLOC) begin
      if (r.block_count != 0 && r.block_count <= NumBlocks) begin
        for (int b = 0; b < NumBlocks && !found; b++) begin
          if (blk_used[b]) begin
            run = 0;
          end else begin
            if (run == 0) first = b;
            run++;
            if (run == r.block_count) found = 1'b1;
          end
        end
      end
      if (!found) begin
        res.status = bfa_pkg::STATUS_FAIL;
        alloc_failed++;
      end else begin
        for (int b = first; b < first + r.block_count; b++) blk_used[b] = 1'b1;
        run_len[first] = r.block_count;
        res.status = bfa_pkg::STATUS_OK;
        res.first_block = first[bfa_pkg::BlockIdxW-1:0];
        alloc_ok++;
      end
    end else begin
      // length is kept after the free; a stale or zero entry is used as is
      stop = r.start_block + run_len[r.start_block];
      if (stop > NumBlocks) stop = NumBlocks;
      for (int b = r.start_block; b < stop; b++) blk_used[b] = 1'b0;
      frees++;
    end
    return res;
  endfunction

  // Issue one request; returns the predicted response once it is taken.
  task automatic send_req(input bfa_pkg::req_t r, output bfa_pkg::rsp_t predicted);
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predicted = alloc_free_step(r);
    rsp_due_q.push_back(predicted);
    if (r.opcode == bfa_pkg::OP_ALLOC && predicted.status == bfa_pkg::STATUS_OK)
      live_runs_q.push_back(predicted.first_block);
  endtask

  // Sender pacing: bursts of back-to-back requests, random gaps between.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic do_alloc(input int count);
    bfa_pkg::req_t r;
    bfa_pkg::rsp_t p;
    r.opcode = bfa_pkg::OP_ALLOC;
    r.block_count = count[bfa_pkg::CountW-1:0];
    r.start_block = bfa_pkg::BlockIdxW'($urandom_range(0, NumBlocks - 1));
    send_req(r, p);
    pace();
  endtask

  task automatic do_free(input int blk);
    bfa_pkg::req_t r;
    bfa_pkg::rsp_t p;
    r.opcode = bfa_pkg::OP_FREE;
    r.block_count = bfa_pkg::CountW'($urandom_range(0, NumBlocks));
    r.start_block = blk[bfa_pkg::BlockIdxW-1:0];
    send_req(r, p);
    pace();
  endtask

  // Result checker: every done_o pulse must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (rsp_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result status=%0b first_block=%0d",
                   rsp_o.status, rsp_o.first_block);
      end else begin
        if (rsp_o.status !== rsp_due_q[0].status ||
            rsp_o.first_block !== rsp_due_q[0].first_block) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status=%0b first_block=%0d, %s%0b first_block=%0d",
                     rsp_due_q[0].status, rsp_due_q[0].first_block, "got status=",
                     rsp_o.status, rsp_o.first_block);
        end
        void'(rsp_due_q.pop_front());
        rsp_checked++;
      end
    end
  end

  // Zero size, whole bitmap, full-word skipping, oversize, frees of
  // unallocated blocks and repeated frees using a stale length.
  task automatic test_directed();
    do_alloc(0);
    do_alloc(NumBlocks);
    do_alloc(1);
    do_free(0);
    do_alloc(64);
    do_alloc(64);
    do_alloc(3);
    do_free(64);
    do_alloc(1);
    do_alloc(70);
    do_free(NumBlocks - 1);
    do_free(500);
    do_alloc(NumBlocks - 200);
    do_free(0);
    do_free(0);
    do_alloc(NumBlocks);
    do_free(64);
    do_free(128);
    do_free(131);
    do_free(65);
    do_alloc(NumBlocks - 1);
    do_alloc(1);
    do_free(NumBlocks - 1);
    do_free(0);
    live_runs_q.delete();
  endtask

  // Mostly alloc/free of live runs with small sizes; some noise frees.
  task automatic test_random();
    int sel, sz, idx;
    for (int n = 0; n < RandomReqs; n++) begin
      sel = $urandom_range(0, 99);
      if (live_runs_q.size() > 0 && sel < ((live_runs_q.size() > 40) ? 70 : 40)) begin
        idx = $urandom_range(0, live_runs_q.size() - 1);
        do_free(live_runs_q[idx]);
        live_runs_q.delete(idx);
      end else if (sel < 50) begin
        do_free($urandom_range(0, NumBlocks - 1));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 4)       sz = 0;
        else if (sel < 75) sz = $urandom_range(1, 16);
        else if (sel < 95) sz = $urandom_range(17, 128);
        else if (sel < 99) sz = $urandom_range(129, 600);
        else               sz = $urandom_range(900, NumBlocks);
        do_alloc(sz);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cycles = 0;
    mismatches = 0;
    rsp_checked = 0;
    alloc_ok = 0;
    alloc_failed = 0;
    frees = 0;
    burst_left = 0;
    foreach (blk_used[i]) begin
      blk_used[i] = 1'b0;
      run_len[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();

    start <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d allocations (%0d failed) and %0d frees, %0d results checked",
             alloc_ok + alloc_failed, alloc_failed, frees, rsp_checked);
    $display("mismatches: %0d, cycles: %0d", mismatches, cycles);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
design/bfa_pkg.sv
design/bfa_ram.sv
design/bfa_ctrl.sv
design/bfa_dp.sv
design/bitmap_first_fit_block_allocator_core.sv
test/tb_top.sv
